@@ rtl/fcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// fcsp_pkg
// Shared widths, codes and control/status bundles for the free cell set
// picker.
// ----------------------------------------------------------------------------
package fcsp_pkg;

  // Port field widths
  localparam int CMD_W     = 2;
  localparam int COORD_W   = 6;
  localparam int PIDX_W    = 12;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 13;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Width for grid dimension compares (covers dimensions up to 511)
  localparam int DIM_W = 9;

  // Smallest grid dimension that still has an interior
  localparam int MIN_DIM = 3;

  // Reset value of both grid dimension registers
  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_PICK   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_HEIGHT = 1'b0,
    REG_GRID_WIDTH  = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_APPLY,
    S_PICK,
    S_INIT,
    S_DONE
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;     // capture request, launch first memory reads
    logic check;      // read list entry at the looked-up slot
    logic apply;      // commit add or remove
    logic pick;       // commit pick
    logic init_step;  // append one interior cell
    logic load_out;   // move the result into the output register
  } ctrl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic init_empty; // configured grid has no interior
    logic init_last;  // current walk cell is the last interior cell
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

@@ rtl/fcsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcsp_ctrl
// Sequencer for the free cell set picker: takes one request at a time and
// steps the datapath through lookup, commit and result hand-off.
// ----------------------------------------------------------------------------
module fcsp_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [fcsp_pkg::CMD_W-1:0]     cmd_i,
  input  fcsp_pkg::stat_t                stat_i,
  output logic                           in_ready_o,
  output fcsp_pkg::ctrl_t                ctrl_o
);

  fcsp_pkg::state_e state_q, state_d;
  logic             fire;

  assign fire = in_valid_i && (state_q == fcsp_pkg::S_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcsp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcsp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (fcsp_pkg::cmd_e'(cmd_i))
            fcsp_pkg::CMD_INIT: begin
              state_d = stat_i.init_empty ? fcsp_pkg::S_DONE : fcsp_pkg::S_INIT;
            end
            fcsp_pkg::CMD_ADD,
            fcsp_pkg::CMD_REMOVE: state_d = fcsp_pkg::S_CHECK;
            fcsp_pkg::CMD_PICK:   state_d = fcsp_pkg::S_PICK;
            default:              state_d = fcsp_pkg::S_IDLE;
          endcase
        end
      end
      fcsp_pkg::S_CHECK: state_d = fcsp_pkg::S_APPLY;
      fcsp_pkg::S_APPLY: state_d = fcsp_pkg::S_DONE;
      fcsp_pkg::S_PICK:  state_d = fcsp_pkg::S_DONE;
      fcsp_pkg::S_INIT: begin
        if (stat_i.init_last) begin
          state_d = fcsp_pkg::S_DONE;
        end
      end
      fcsp_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          state_d = fcsp_pkg::S_IDLE;
        end
      end
      default: state_d = fcsp_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o          = '0;
    in_ready_o      = 1'b0;
    unique case (state_q)
      fcsp_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = fire;
      end
      fcsp_pkg::S_CHECK: ctrl_o.check     = 1'b1;
      fcsp_pkg::S_APPLY: ctrl_o.apply     = 1'b1;
      fcsp_pkg::S_PICK:  ctrl_o.pick      = 1'b1;
      fcsp_pkg::S_INIT:  ctrl_o.init_step = 1'b1;
      fcsp_pkg::S_DONE:  ctrl_o.load_out  = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/fcsp_dpath.sv @@
// ----------------------------------------------------------------------------
// fcsp_dpath
// Datapath of the free cell set picker: grid registers, the dense cell list,
// the per-cell slot table, the live count, the chosen position and the
// output register.
// ----------------------------------------------------------------------------
module fcsp_dpath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [fcsp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fcsp_pkg::CFG_W-1:0]        cfg_data_i,
  // request fields
  input  logic [fcsp_pkg::CMD_W-1:0]        cmd_i,
  input  logic [fcsp_pkg::COORD_W-1:0]      cell_row_i,
  input  logic [fcsp_pkg::COORD_W-1:0]      cell_col_i,
  input  logic [fcsp_pkg::PIDX_W-1:0]       pick_index_i,
  // control
  input  fcsp_pkg::ctrl_t                   ctrl_i,
  output fcsp_pkg::stat_t                   stat_o,
  // result
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fcsp_pkg::STATUS_W-1:0]     status_o,
  output logic [fcsp_pkg::COORD_W-1:0]      chosen_row_o,
  output logic [fcsp_pkg::COORD_W-1:0]      chosen_col_o,
  output logic [fcsp_pkg::COUNT_W-1:0]      free_count_o
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ENT_W  = ROW_W + COL_W;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int CMP_W  = (fcsp_pkg::PIDX_W > CNT_W) ? fcsp_pkg::PIDX_W : CNT_W;
  localparam int DIM_W  = fcsp_pkg::DIM_W;

  // List entries hold {row, col}; the slot table is indexed by row*MAX_COLS+col
  function automatic logic [ADDR_W-1:0] ent_to_addr(input logic [ENT_W-1:0] ent);
    ent_to_addr = ADDR_W'(ent[ENT_W-1:COL_W]) * ADDR_W'(MAX_COLS)
                + ADDR_W'(ent[COL_W-1:0]);
  endfunction

  // Memories
  logic [ENT_W-1:0]  list_mem [CELLS];
  logic [ADDR_W-1:0] slot_mem [CELLS];

  // Registers
  logic [fcsp_pkg::CFG_W-1:0]    grid_h_q, grid_w_q;
  fcsp_pkg::cmd_e                cmd_q;
  logic [ENT_W-1:0]              ent_q;
  logic [ADDR_W-1:0]             addr_q;
  logic                          off_grid_q;
  logic [fcsp_pkg::PIDX_W-1:0]   pidx_q;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [ADDR_W-1:0]             slot_rd_q;
  logic [ENT_W-1:0]              list_rd_q;
  logic [ENT_W-1:0]              last_q;
  logic [ROW_W-1:0]              y_q;
  logic [COL_W-1:0]              x_q;
  fcsp_pkg::status_e             status_q, status_d;
  logic [fcsp_pkg::COORD_W-1:0]  chosen_row_q, chosen_col_q;
  logic                          out_valid_q;
  fcsp_pkg::status_e             out_status_q;
  logic [fcsp_pkg::COORD_W-1:0]  out_row_q, out_col_q;
  logic [fcsp_pkg::COUNT_W-1:0]  out_count_q;

  // Combinational
  logic [ENT_W-1:0]  in_ent;
  logic [ADDR_W-1:0] in_addr;
  logic              in_off;
  logic [DIM_W-1:0]  h_cap, w_cap, gh, gw;
  logic [ENT_W-1:0]  walk_ent;
  logic              present, full, pick_ok;
  logic [ADDR_W-1:0] count_lo, last_idx;
  logic              list_we, slot_we, list_re, slot_re;
  logic [ADDR_W-1:0] list_waddr, slot_waddr, list_raddr, slot_raddr;
  logic [ENT_W-1:0]  list_wdata;
  logic [ADDR_W-1:0] slot_wdata;
  logic              add_ok, rem_ok;

  // Request decode
  assign in_ent  = {ROW_W'(cell_row_i), COL_W'(cell_col_i)};
  assign in_addr = ent_to_addr(in_ent);
  assign in_off  = (DIM_W'(cell_row_i) >= DIM_W'(MAX_ROWS))
                || (DIM_W'(cell_col_i) >= DIM_W'(MAX_COLS));

  // Grid bounds capped at the array size
  assign gh    = DIM_W'(grid_h_q);
  assign gw    = DIM_W'(grid_w_q);
  assign h_cap = (gh > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : gh;
  assign w_cap = (gw > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : gw;

  assign stat_o.init_empty = (h_cap < DIM_W'(fcsp_pkg::MIN_DIM))
                          || (w_cap < DIM_W'(fcsp_pkg::MIN_DIM));
  assign stat_o.init_last  = (DIM_W'(y_q) == h_cap - DIM_W'(2))
                          && (DIM_W'(x_q) == w_cap - DIM_W'(2));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign walk_ent = {y_q, x_q};
  assign count_lo = count_q[ADDR_W-1:0];
  assign last_idx = ADDR_W'(count_q - CNT_W'(1));
  assign full     = count_q >= CNT_W'(CELLS);
  assign pick_ok  = CMP_W'(pidx_q) < CMP_W'(count_q);

  // Membership: slot in range and the list entry there points back at the cell
  always_comb begin
    present = 1'b0;
    if (count_q != '0) begin
      if (CNT_W'(slot_rd_q) < count_q) begin
        if (list_rd_q == ent_q) begin
          present = 1'b1;
        end
      end
    end
  end

  assign add_ok = ctrl_i.apply && (cmd_q == fcsp_pkg::CMD_ADD) && !off_grid_q
               && !present && !full;
  assign rem_ok = ctrl_i.apply && (cmd_q == fcsp_pkg::CMD_REMOVE) && !off_grid_q
               && present;

  // Memory port steering
  always_comb begin
    list_re    = ctrl_i.accept || ctrl_i.check;
    slot_re    = ctrl_i.accept;
    list_raddr = slot_rd_q;
    slot_raddr = in_addr;
    if (ctrl_i.accept) begin
      list_raddr = (fcsp_pkg::cmd_e'(cmd_i) == fcsp_pkg::CMD_PICK)
                 ? ADDR_W'(pick_index_i) : last_idx;
    end

    list_we    = 1'b0;
    slot_we    = 1'b0;
    list_waddr = count_lo;
    list_wdata = ent_q;
    slot_waddr = addr_q;
    slot_wdata = count_lo;
    if (ctrl_i.init_step) begin
      list_we    = 1'b1;
      slot_we    = 1'b1;
      list_wdata = walk_ent;
      slot_waddr = ent_to_addr(walk_ent);
    end else if (add_ok) begin
      list_we = 1'b1;
      slot_we = 1'b1;
    end else if (rem_ok) begin
      // swap the last entry into the removed slot
      list_we    = 1'b1;
      slot_we    = 1'b1;
      list_waddr = slot_rd_q;
      list_wdata = last_q;
      slot_waddr = ent_to_addr(last_q);
      slot_wdata = slot_rd_q;
    end
  end

  // Dense cell list
  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_raddr];
    end
  end

  // Slot table
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  // Live count and result status
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (ctrl_i.accept) begin
      status_d = fcsp_pkg::ST_OK;
      if (fcsp_pkg::cmd_e'(cmd_i) == fcsp_pkg::CMD_INIT) begin
        count_d = '0;
      end
    end
    if (ctrl_i.init_step || add_ok) begin
      count_d = count_q + CNT_W'(1);
    end
    if (rem_ok) begin
      count_d = count_q - CNT_W'(1);
    end
    if (ctrl_i.apply) begin
      if (off_grid_q) begin
        status_d = fcsp_pkg::ST_RANGE;
      end else if (cmd_q == fcsp_pkg::CMD_ADD) begin
        if (present) begin
          status_d = fcsp_pkg::ST_PRESENT;
        end else if (full) begin
          status_d = fcsp_pkg::ST_RANGE;
        end else begin
          status_d = fcsp_pkg::ST_OK;
        end
      end else begin
        if (present) begin
          status_d = fcsp_pkg::ST_OK;
        end else begin
          status_d = fcsp_pkg::ST_ABSENT;
        end
      end
    end
    if (ctrl_i.pick) begin
      status_d = pick_ok ? fcsp_pkg::ST_OK : fcsp_pkg::ST_RANGE;
    end
  end

  // Control state: grid config, count, chosen position, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_h_q     <= fcsp_pkg::GRID_RESET;
      grid_w_q     <= fcsp_pkg::GRID_RESET;
      count_q      <= '0;
      chosen_row_q <= '0;
      chosen_col_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (fcsp_pkg::reg_e'(cfg_index_i))
          fcsp_pkg::REG_GRID_HEIGHT: grid_h_q <= cfg_data_i;
          fcsp_pkg::REG_GRID_WIDTH:  grid_w_q <= cfg_data_i;
          default: ;
        endcase
      end
      count_q <= count_d;
      if (ctrl_i.pick && pick_ok) begin
        chosen_row_q <= fcsp_pkg::COORD_W'(list_rd_q[ENT_W-1:COL_W]);
        chosen_col_q <= fcsp_pkg::COORD_W'(list_rd_q[COL_W-1:0]);
      end
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (ctrl_i.accept) begin
      cmd_q      <= fcsp_pkg::cmd_e'(cmd_i);
      ent_q      <= in_ent;
      addr_q     <= in_addr;
      off_grid_q <= in_off;
      pidx_q     <= pick_index_i;
      y_q        <= ROW_W'(1);
      x_q        <= COL_W'(1);
    end
    if (ctrl_i.check) begin
      last_q <= list_rd_q;
    end
    // interior walk, row-major
    if (ctrl_i.init_step) begin
      if (DIM_W'(x_q) == w_cap - DIM_W'(2)) begin
        x_q <= COL_W'(1);
        y_q <= y_q + ROW_W'(1);
      end else begin
        x_q <= x_q + COL_W'(1);
      end
    end
    if (ctrl_i.load_out) begin
      out_status_q <= status_q;
      out_row_q    <= chosen_row_q;
      out_col_q    <= chosen_col_q;
      out_count_q  <= fcsp_pkg::COUNT_W'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign chosen_row_o = out_row_q;
  assign chosen_col_o = out_col_q;
  assign free_count_o = out_count_q;

endmodule

@@ rtl/free_cell_set_picker.sv @@
// ----------------------------------------------------------------------------
// free_cell_set_picker
// Free grid cell set with constant-time add, swap-remove and pick by index.
//
// One request is in flight at a time. Add and remove go from acceptance to
// a result in the output register through a slot table read, a list read
// to confirm membership, a commit step with the swap writes and a hand-off
// step; pick reads the list at acceptance, then commits and hands off. Init
// appends the interior of the grid registers, capped at MAX_ROWS and
// MAX_COLS, one cell per cycle through the list write port; a grid with
// either dimension under 3 has no interior and its init goes straight to
// hand-off. A finished result waits in the output register while the next
// request is accepted. Membership is checked by the list pointing back at
// the cell, so the slot table needs no clearing after reset or on init, and
// there is no start-up pass.
// ----------------------------------------------------------------------------
module free_cell_set_picker #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [fcsp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fcsp_pkg::CFG_W-1:0]        cfg_data_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fcsp_pkg::CMD_W-1:0]        cmd_i,
  input  logic [fcsp_pkg::COORD_W-1:0]      cell_row_i,
  input  logic [fcsp_pkg::COORD_W-1:0]      cell_col_i,
  input  logic [fcsp_pkg::PIDX_W-1:0]       pick_index_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fcsp_pkg::STATUS_W-1:0]     status_o,
  output logic [fcsp_pkg::COORD_W-1:0]      chosen_row_o,
  output logic [fcsp_pkg::COORD_W-1:0]      chosen_col_o,
  output logic [fcsp_pkg::COUNT_W-1:0]      free_count_o
);

  fcsp_pkg::ctrl_t ctrl;
  fcsp_pkg::stat_t stat;

  // Sequencer
  fcsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  // Storage and result path
  fcsp_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .pick_index_i (pick_index_i),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .chosen_row_o (chosen_row_o),
    .chosen_col_o (chosen_col_o),
    .free_count_o (free_count_o)
  );

endmodule

@@ rtl/fcsp_checker.sv @@
// ----------------------------------------------------------------------------
// fcsp_checker
// Port-level checks for the free cell set picker, bound to the top level.
// ----------------------------------------------------------------------------
module fcsp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [fcsp_pkg::STATUS_W-1:0]     status_o,
  input  logic [fcsp_pkg::COORD_W-1:0]      chosen_row_o,
  input  logic [fcsp_pkg::COORD_W-1:0]      chosen_col_o,
  input  logic [fcsp_pkg::COUNT_W-1:0]      free_count_o
);

  logic                          out_fire;
  logic                          seen_q;
  logic [fcsp_pkg::COUNT_W-1:0]  last_count_q;
  logic [fcsp_pkg::COORD_W-1:0]  last_row_q, last_col_q;

  assign out_fire = out_valid_o && out_ready_i;

  // Last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_count_q <= '0;
      last_row_q   <= '0;
      last_col_q   <= '0;
    end else if (out_fire) begin
      seen_q       <= 1'b1;
      last_count_q <= free_count_o;
      last_row_q   <= chosen_row_o;
      last_col_q   <= chosen_col_o;
    end
  end

  // Stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(chosen_row_o) && $stable(chosen_col_o) && $stable(free_count_o))
    else $error("result changed while stalled");

  // One request in flight: ready drops right after an accept
  a_single_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in flight");

  // A refused request leaves the set size alone
  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && seen_q && (status_o != fcsp_pkg::ST_OK)
      |-> free_count_o == last_count_q)
    else $error("free count moved on a refused request");

  // The chosen position moves only on a successful pick
  a_chosen_by_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && ((chosen_row_o != last_row_q) || (chosen_col_o != last_col_q))
      |-> status_o == fcsp_pkg::ST_OK)
    else $error("chosen position moved without a successful pick");

endmodule

bind free_cell_set_picker fcsp_checker u_fcsp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .chosen_row_o (chosen_row_o),
  .chosen_col_o (chosen_col_o),
  .free_count_o (free_count_o)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the free cell set picker. Requests go in over a
// valid/ready channel, and the bench keeps its own copy of the sparse set
// (dense list, slot table, presence flags, chosen position) to work out each
// result. Every result is checked field by field against the oldest pending
// expectation. The run covers directed corner cases first, then random
// traffic over several grid shapes and several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int     ROWS          = 64;
  localparam int     COLS          = 64;
  localparam int     CELLS         = ROWS * COLS;
  localparam int     SETTLE_CYCLES = 4;
  localparam longint LIMIT_NS      = 100_000_000;

  typedef struct packed {
    fcsp_pkg::status_e                  status;
    logic [fcsp_pkg::COORD_W-1:0]       row;
    logic [fcsp_pkg::COORD_W-1:0]       col;
    logic [fcsp_pkg::COUNT_W-1:0]       count;
  } set_result_t;

  // Clock, reset and block inputs, all known from time zero
  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          cfg_we_i     = 1'b0;
  fcsp_pkg::reg_e                cfg_index_i  = fcsp_pkg::REG_GRID_HEIGHT;
  logic [fcsp_pkg::CFG_W-1:0]    cfg_data_i   = '0;
  logic                          in_valid_i   = 1'b0;
  fcsp_pkg::cmd_e                cmd_i        = fcsp_pkg::CMD_INIT;
  logic [fcsp_pkg::COORD_W-1:0]  cell_row_i   = '0;
  logic [fcsp_pkg::COORD_W-1:0]  cell_col_i   = '0;
  logic [fcsp_pkg::PIDX_W-1:0]   pick_index_i = '0;
  logic                          out_ready_i  = 1'b0;

  logic                          in_ready_o;
  logic                          out_valid_o;
  logic [fcsp_pkg::STATUS_W-1:0] status_o;
  logic [fcsp_pkg::COORD_W-1:0]  chosen_row_o;
  logic [fcsp_pkg::COORD_W-1:0]  chosen_col_o;
  logic [fcsp_pkg::COUNT_W-1:0]  free_count_o;

  // Idle mix, in percent of cycles
  int req_idle_pct  = 0;
  int rsp_stall_pct = 0;
  int mismatch_cnt  = 0;

  set_result_t pending_results[$];

  // Mirror of the free set
  logic [fcsp_pkg::PIDX_W-1:0]   list_mem  [CELLS];
  logic [fcsp_pkg::COUNT_W-1:0]  slot_mem  [CELLS];
  bit                            present   [CELLS];
  logic [fcsp_pkg::COUNT_W-1:0]  live_cnt      = '0;
  logic [fcsp_pkg::COORD_W-1:0]  chosen_row_q  = '0;
  logic [fcsp_pkg::COORD_W-1:0]  chosen_col_q  = '0;
  int                            grid_rows_cfg = int'(fcsp_pkg::GRID_RESET);
  int                            grid_cols_cfg = int'(fcsp_pkg::GRID_RESET);

  free_cell_set_picker #(
    .MAX_ROWS(ROWS),
    .MAX_COLS(COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .pick_index_i (pick_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .chosen_row_o (chosen_row_o),
    .chosen_col_o (chosen_col_o),
    .free_count_o (free_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Append a cell to the mirrored set
  function automatic fcsp_pkg::status_e add_cell(int addr);
    if (present[addr]) return fcsp_pkg::ST_PRESENT;
    if (live_cnt >= CELLS) return fcsp_pkg::ST_RANGE;
    list_mem[live_cnt] = fcsp_pkg::PIDX_W'(addr);
    slot_mem[addr]     = live_cnt;
    present[addr]      = 1'b1;
    live_cnt           = live_cnt + 1'b1;
    return fcsp_pkg::ST_OK;
  endfunction

  // Apply one request to the mirrored set and return the result it causes
  function automatic set_result_t predict_set_result(fcsp_pkg::cmd_e op,
                                                     logic [fcsp_pkg::COORD_W-1:0] row,
                                                     logic [fcsp_pkg::COORD_W-1:0] col,
                                                     logic [fcsp_pkg::PIDX_W-1:0] idx);
    set_result_t                  res;
    int                           h, w, addr, slot, last;
    logic [fcsp_pkg::PIDX_W-1:0]  moved;
    res.status = fcsp_pkg::ST_OK;
    addr = int'(row) * COLS + int'(col);
    case (op)
      fcsp_pkg::CMD_INIT: begin
        h = (grid_rows_cfg > ROWS) ? ROWS : grid_rows_cfg;
        w = (grid_cols_cfg > COLS) ? COLS : grid_cols_cfg;
        for (int i = 0; i < CELLS; i++) begin
          present[i]  = 1'b0;
          slot_mem[i] = '0;
        end
        live_cnt = '0;
        // interior only, row-major; a grid under 3 leaves the set empty
        for (int y = 1; y + 1 < h; y++) begin
          for (int x = 1; x + 1 < w; x++) begin
            void'(add_cell(y * COLS + x));
          end
        end
      end
      fcsp_pkg::CMD_ADD, fcsp_pkg::CMD_REMOVE: begin
        if (row >= ROWS || col >= COLS) begin
          res.status = fcsp_pkg::ST_RANGE;
        end else if (op == fcsp_pkg::CMD_ADD) begin
          res.status = add_cell(addr);
        end else if (!present[addr] || live_cnt == 0) begin
          res.status = fcsp_pkg::ST_ABSENT;
        end else begin
          // swap with the last entry; dropping the last entry falls out of this
          slot = int'(slot_mem[addr]);
          last = int'(live_cnt) - 1;
          if (slot > last) slot = last;
          moved = list_mem[last];
          list_mem[slot] = moved;
          slot_mem[moved] = fcsp_pkg::COUNT_W'(slot);
          present[addr] = 1'b0;
          live_cnt = fcsp_pkg::COUNT_W'(last);
        end
      end
      default: begin
        if (live_cnt == 0 || idx >= live_cnt) begin
          res.status = fcsp_pkg::ST_RANGE;
        end else begin
          chosen_row_q = fcsp_pkg::COORD_W'(int'(list_mem[idx]) / COLS);
          chosen_col_q = fcsp_pkg::COORD_W'(int'(list_mem[idx]) % COLS);
        end
      end
    endcase
    res.row   = chosen_row_q;
    res.col   = chosen_col_q;
    res.count = live_cnt;
    return res;
  endfunction

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    set_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: status %0d row %0d col %0d count %0d",
                 $time, status_o, chosen_row_o, chosen_col_o, free_count_o);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (status_o != want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          mismatch_cnt++;
        end
        if (chosen_row_o != want.row) begin
          $display("%0t: chosen_row expected %0d got %0d", $time, want.row, chosen_row_o);
          mismatch_cnt++;
        end
        if (chosen_col_o != want.col) begin
          $display("%0t: chosen_col expected %0d got %0d", $time, want.col, chosen_col_o);
          mismatch_cnt++;
        end
        if (free_count_o != want.count) begin
          $display("%0t: free_count expected %0d got %0d", $time, want.count, free_count_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Send one request; the optional gap comes first so valid is never dropped
  // and raised in the same step
  task automatic send_request(input fcsp_pkg::cmd_e op,
                              input logic [fcsp_pkg::COORD_W-1:0] row,
                              input logic [fcsp_pkg::COORD_W-1:0] col,
                              input logic [fcsp_pkg::PIDX_W-1:0] idx);
    if ($urandom_range(99) < req_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < req_idle_pct);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    cell_row_i   <= row;
    cell_col_i   <= col;
    pick_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), predict_set_result(op, row, col, idx));
  endtask

  // Stop sending and let every pending result drain
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both grid registers while the block is idle
  task automatic set_grid(input int h, input int w);
    wait_for_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= fcsp_pkg::REG_GRID_HEIGHT;
    cfg_data_i  <= fcsp_pkg::CFG_W'(h);
    @(posedge clk_i);
    grid_rows_cfg = h;
    cfg_index_i <= fcsp_pkg::REG_GRID_WIDTH;
    cfg_data_i  <= fcsp_pkg::CFG_W'(w);
    @(posedge clk_i);
    grid_cols_cfg = w;
    cfg_we_i <= 1'b0;
  endtask

  // Empty set handling, duplicate add, absent remove, swap and last-entry remove
  task automatic test_empty_set_ops();
    send_request(fcsp_pkg::CMD_PICK,   0,  0,  0);
    send_request(fcsp_pkg::CMD_REMOVE, 5,  5,  0);
    send_request(fcsp_pkg::CMD_ADD,    63, 63, 0);
    send_request(fcsp_pkg::CMD_ADD,    63, 63, 0);
    send_request(fcsp_pkg::CMD_ADD,    0,  0,  4095);
    send_request(fcsp_pkg::CMD_PICK,   0,  0,  1);
    send_request(fcsp_pkg::CMD_REMOVE, 63, 63, 0);
    send_request(fcsp_pkg::CMD_REMOVE, 63, 63, 0);
    send_request(fcsp_pkg::CMD_REMOVE, 0,  0,  0);
  endtask

  // Init over the smallest, empty, capped and full grids
  task automatic test_grid_init();
    set_grid(3, 3);
    send_request(fcsp_pkg::CMD_INIT, 0, 0, 0);
    send_request(fcsp_pkg::CMD_PICK, 0, 0, 0);
    set_grid(2, 64);
    send_request(fcsp_pkg::CMD_INIT, 63, 63, 4095);
    set_grid(0, 0);
    send_request(fcsp_pkg::CMD_INIT, 0, 0, 0);
    send_request(fcsp_pkg::CMD_PICK, 0, 0, 0);
    // registers above the bounds are capped
    set_grid(127, 127);
    send_request(fcsp_pkg::CMD_INIT,   0, 0, 0);
    send_request(fcsp_pkg::CMD_PICK,   0, 0, 3843);
    send_request(fcsp_pkg::CMD_PICK,   0, 0, 3844);
    send_request(fcsp_pkg::CMD_REMOVE, 1, 1, 0);
    send_request(fcsp_pkg::CMD_ADD,    1, 1, 0);
    send_request(fcsp_pkg::CMD_PICK,   0, 0, 3843);
    set_grid(64, 64);
    send_request(fcsp_pkg::CMD_INIT, 0, 0, 0);
    send_request(fcsp_pkg::CMD_PICK, 0, 0, 0);
    // a border cell outside the configured interior is still accepted
    set_grid(5, 4);
    send_request(fcsp_pkg::CMD_INIT,   0, 0, 0);
    send_request(fcsp_pkg::CMD_ADD,    4, 3, 0);
    send_request(fcsp_pkg::CMD_REMOVE, 1, 1, 0);
  endtask

  // Random traffic in segments, each on a fresh grid shape starting with init
  task automatic test_random_traffic(input int n_items);
    int                            done_cnt, seg_left, roll, h, w, row_span, col_span;
    logic [fcsp_pkg::COORD_W-1:0]  r, c;
    logic [fcsp_pkg::PIDX_W-1:0]   p, addr;
    fcsp_pkg::cmd_e                op;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      // mostly small grids, now and then an empty, capped or arbitrary one
      roll = $urandom_range(15);
      case (roll)
        0: begin h = $urandom_range(127);     w = $urandom_range(127);     end
        1: begin h = $urandom_range(2);       w = $urandom_range(3, 16);   end
        2: begin h = $urandom_range(3, 16);   w = $urandom_range(2);       end
        3: begin h = $urandom_range(64, 127); w = $urandom_range(64, 127); end
        default: begin h = $urandom_range(3, 14); w = $urandom_range(3, 14); end
      endcase
      set_grid(h, w);
      row_span = ((h > ROWS) ? ROWS : h) + 1;
      col_span = ((w > COLS) ? COLS : w) + 1;
      if (row_span > ROWS - 1) row_span = ROWS - 1;
      if (col_span > COLS - 1) col_span = COLS - 1;
      send_request(fcsp_pkg::CMD_INIT, fcsp_pkg::COORD_W'($urandom),
                   fcsp_pkg::COORD_W'($urandom), fcsp_pkg::PIDX_W'($urandom));
      done_cnt++;
      seg_left = 64;
      while (seg_left > 0 && done_cnt < n_items) begin
        r = fcsp_pkg::COORD_W'($urandom);
        c = fcsp_pkg::COORD_W'($urandom);
        p = fcsp_pkg::PIDX_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 4)       op = fcsp_pkg::CMD_INIT;
        else if (roll < 40) op = fcsp_pkg::CMD_ADD;
        else if (roll < 70) op = fcsp_pkg::CMD_REMOVE;
        else                op = fcsp_pkg::CMD_PICK;
        roll = $urandom_range(99);
        if (op == fcsp_pkg::CMD_ADD || op == fcsp_pkg::CMD_REMOVE) begin
          // a listed cell (often the last one), a cell near the grid, or anywhere
          if (roll < ((op == fcsp_pkg::CMD_ADD) ? 15 : 45) && live_cnt != 0) begin
            addr = (roll < 10) ? list_mem[live_cnt - 1]
                               : list_mem[$urandom_range(int'(live_cnt) - 1)];
            r = fcsp_pkg::COORD_W'(int'(addr) / COLS);
            c = fcsp_pkg::COORD_W'(int'(addr) % COLS);
          end else if (roll < 85) begin
            r = fcsp_pkg::COORD_W'($urandom_range(row_span));
            c = fcsp_pkg::COORD_W'($urandom_range(col_span));
          end
        end else if (op == fcsp_pkg::CMD_PICK) begin
          if (roll < 80 && live_cnt != 0) begin
            p = fcsp_pkg::PIDX_W'($urandom_range(int'(live_cnt) - 1));
          end else if (roll < 90) begin
            p = fcsp_pkg::PIDX_W'(int'(live_cnt) + $urandom_range(2));
          end
        end
        send_request(op, r, c, p);
        done_cnt++;
        seg_left--;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_set_ops();
    test_grid_init();

    req_idle_pct = 0;  rsp_stall_pct = 0;
    test_random_traffic(330);
    req_idle_pct = 82; rsp_stall_pct = 0;
    test_random_traffic(320);
    req_idle_pct = 0;  rsp_stall_pct = 82;
    test_random_traffic(320);
    req_idle_pct = 8;  rsp_stall_pct = 8;
    test_random_traffic(330);

    wait_for_idle();
    if (mismatch_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
